>>> design/mpl_pkg.sv
package mpl_pkg;

    // default number of watermarks (levels run 0 .. NUM_WATERMARKS)
    localparam int NUM_WATERMARKS_DEF = 4;
    // watermarks that have a register; any beyond these read as all ones
    localparam int NUM_WM_REGS = 4;

    localparam int DATA_W    = 32;
    localparam int LEVEL_W   = 3;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WM_OOM       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WM_IMMINENT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WM_CRITICAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WM_WARNING   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EVICT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd7;

    // mode flag bits
    localparam int MODE_EVICT_TARGET = 0;
    localparam int MODE_OOM_ON_FAIL  = 1;
    localparam int MODE_CONTINUOUS   = 2;

    // reset values, watermark 0 in the lowest slot
    localparam logic [NUM_WM_REGS-1:0][DATA_W-1:0] WM_RESET =
        {32'd76800, 32'd38400, 32'd12800, 32'd12800};
    localparam logic [DATA_W-1:0]  DEBOUNCE_RESET   = 32'd256;
    localparam logic [DATA_W-1:0]  HYSTERESIS_RESET = 32'd10;
    localparam logic [LEVEL_W-1:0] MAX_EVICT_RESET  = 3'd2;
    localparam logic [MODE_W-1:0]  MODE_RESET       = 3'd0;

    // scalar configuration
    typedef struct packed {
        logic [DATA_W-1:0]  debounce_pages;
        logic [DATA_W-1:0]  hysteresis_ticks;
        logic [LEVEL_W-1:0] max_evict_level;
        logic [MODE_W-1:0]  mode_flags;
    } t_cfg;

    // one result word
    typedef struct packed {
        logic               oom_response;
        logic               continuous_active;
        logic [DATA_W-1:0]  min_free_target;
        logic               evict_request;
        logic [LEVEL_W-1:0] cleared_level;
        logic               signal_due;
        logic [LEVEL_W-1:0] level;
    } t_result;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;
    localparam int RESULT_W    = $bits(t_result);

endpackage

>>> design/memory_pressure_level_monitor.sv
// Memory pressure level monitor. Each input word is one sample: free pages in
// s_tdata[31:0], a wrapping tick timestamp in s_tdata[63:32] and the allocation
// failure flag in s_tdata[64]. For every sample one result word comes out with the
// new level (0 out of memory .. NUM_WATERMARKS normal), whether it is signalled,
// the level it replaces, an eviction request with its minimum free target, the
// continuous eviction state and the out-of-memory response flag. A sample can be
// taken every cycle while results are taken; it waits in the input register, then
// one pass of compare logic writes its result word into the output register, and
// the level state moves with each sample so the next one sees it at once. Input
// stalls only while the output register holds a word that is not taken. The user
// must write the configuration registers through the cfg port only while the block
// has no sample in flight; the block itself does not enforce this.
module memory_pressure_level_monitor #(
    parameter int NUM_WATERMARKS = mpl_pkg::NUM_WATERMARKS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [mpl_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [mpl_pkg::DATA_W-1:0]          i_cfg_wr_data,
    // sample stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // free page count, now_ticks, alloc_failed, zero pad
    input  logic [mpl_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // result stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // level, signal_due, cleared_level, evict_request, min_free_target,
    // continuous_active, oom_response, zero pad
    output logic [mpl_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    localparam int LW = $clog2(NUM_WATERMARKS + 1);
    localparam int DW = mpl_pkg::DATA_W;

    logic [NUM_WATERMARKS-1:0][DW-1:0] wm;
    mpl_pkg::t_cfg                     cfg;

    logic                 r_in_valid;
    logic [DW-1:0]        r_free;
    logic [DW-1:0]        r_now;
    logic                 r_alloc;

    logic [LW-1:0]        r_cur_level;
    logic [LW-1:0]        r_sig_level;
    logic [DW-1:0]        r_last_time;
    logic                 r_cont_on;

    logic [LW-1:0]        n_cur_level;
    logic [LW-1:0]        n_sig_level;
    logic                 n_cont_on;
    mpl_pkg::t_result     n_result;

    logic                 r_out_valid;
    mpl_pkg::t_result     r_result;

    logic                 advance;

    mpl_cfg_regs #(
        .NUM_WATERMARKS (NUM_WATERMARKS)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_wm          (wm),
        .o_cfg         (cfg)
    );

    mpl_eval #(
        .NUM_WATERMARKS (NUM_WATERMARKS),
        .LW             (LW)
    ) u_eval (
        .i_wm           (wm),
        .i_cfg          (cfg),
        .i_free_cnt     (r_free),
        .i_now_ticks    (r_now),
        .i_alloc_failed (r_alloc),
        .i_cur_level    (r_cur_level),
        .i_sig_level    (r_sig_level),
        .i_last_time    (r_last_time),
        .i_cont_on      (r_cont_on),
        .o_level        (n_cur_level),
        .o_sig_level    (n_sig_level),
        .o_cont_on      (n_cont_on),
        .o_result       (n_result)
    );

    // a word moves to the output when that register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_free  <= i_s_tdata[DW-1:0];
            r_now   <= i_s_tdata[2*DW-1:DW];
            r_alloc <= i_s_tdata[2*DW];
        end
    end

    // level state, updated as each word is evaluated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_level <= LW'(NUM_WATERMARKS);
            r_sig_level <= LW'(NUM_WATERMARKS);
            r_last_time <= '0;
            r_cont_on   <= 1'b0;
        end else if (advance) begin
            r_cur_level <= n_cur_level;
            r_sig_level <= n_sig_level;
            r_last_time <= r_now;
            r_cont_on   <= n_cont_on;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(mpl_pkg::OUT_TDATA_W - mpl_pkg::RESULT_W){1'b0}}, r_result};

endmodule

>>> design/mpl_cfg_regs.sv
module mpl_cfg_regs #(
    parameter int NUM_WATERMARKS = mpl_pkg::NUM_WATERMARKS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_cfg_wr_en,
    input  logic [mpl_pkg::CFG_IDX_W-1:0]                  i_cfg_addr,
    input  logic [mpl_pkg::DATA_W-1:0]                     i_cfg_wr_data,
    output logic [NUM_WATERMARKS-1:0][mpl_pkg::DATA_W-1:0] o_wm,
    output mpl_pkg::t_cfg                                  o_cfg
);

    localparam int RN = (NUM_WATERMARKS < mpl_pkg::NUM_WM_REGS) ?
                        NUM_WATERMARKS : mpl_pkg::NUM_WM_REGS;

    logic [RN-1:0][mpl_pkg::DATA_W-1:0] r_wm;
    mpl_pkg::t_cfg                      r_cfg;

    // watermark registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RN; i++) begin
                r_wm[i] <= mpl_pkg::WM_RESET[i];
            end
        end else if (i_cfg_wr_en) begin
            for (int i = 0; i < RN; i++) begin
                if (i_cfg_addr == mpl_pkg::CFG_IDX_W'(i)) begin
                    r_wm[i] <= i_cfg_wr_data;
                end
            end
        end
    end

    // scalar registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_pages   <= mpl_pkg::DEBOUNCE_RESET;
            r_cfg.hysteresis_ticks <= mpl_pkg::HYSTERESIS_RESET;
            r_cfg.max_evict_level  <= mpl_pkg::MAX_EVICT_RESET;
            r_cfg.mode_flags       <= mpl_pkg::MODE_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                mpl_pkg::CFG_DEBOUNCE:   r_cfg.debounce_pages   <= i_cfg_wr_data;
                mpl_pkg::CFG_HYSTERESIS: r_cfg.hysteresis_ticks <= i_cfg_wr_data;
                mpl_pkg::CFG_MAX_EVICT:  r_cfg.max_evict_level  <=
                                             i_cfg_wr_data[mpl_pkg::LEVEL_W-1:0];
                mpl_pkg::CFG_MODE:       r_cfg.mode_flags       <=
                                             i_cfg_wr_data[mpl_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // watermarks without a register sit at all ones
    genvar g;
    generate
        for (g = 0; g < NUM_WATERMARKS; g++) begin : g_wm
            if (g < RN) begin : g_reg
                assign o_wm[g] = r_wm[g];
            end else begin : g_const
                assign o_wm[g] = '1;
            end
        end
    endgenerate

    assign o_cfg = r_cfg;

endmodule

>>> design/mpl_eval.sv
module mpl_eval #(
    parameter int NUM_WATERMARKS = mpl_pkg::NUM_WATERMARKS_DEF,
    parameter int LW             = $clog2(NUM_WATERMARKS + 1)
) (
    input  logic [NUM_WATERMARKS-1:0][mpl_pkg::DATA_W-1:0] i_wm,
    input  mpl_pkg::t_cfg                                  i_cfg,
    input  logic [mpl_pkg::DATA_W-1:0]                     i_free_cnt,
    input  logic [mpl_pkg::DATA_W-1:0]                     i_now_ticks,
    input  logic                                           i_alloc_failed,
    input  logic [LW-1:0]                                  i_cur_level,
    input  logic [LW-1:0]                                  i_sig_level,
    input  logic [mpl_pkg::DATA_W-1:0]                     i_last_time,
    input  logic                                           i_cont_on,
    output logic [LW-1:0]                                  o_level,
    output logic [LW-1:0]                                  o_sig_level,
    output logic                                           o_cont_on,
    output mpl_pkg::t_result                               o_result
);

    localparam int DW = mpl_pkg::DATA_W;
    localparam int WI = $clog2(NUM_WATERMARKS);
    localparam int CW = (LW > mpl_pkg::LEVEL_W) ? LW : mpl_pkg::LEVEL_W;
    localparam logic [LW-1:0] TOP_LEVEL = LW'(NUM_WATERMARKS);

    logic [WI-1:0]         up_idx;
    logic [WI-1:0]         lo_idx;
    logic [DW-1:0]         w_lo;
    logic [DW-1:0]         lower;
    logic [DW:0]           upper;
    logic                  in_range;
    logic [NUM_WATERMARKS-1:0] above;
    logic [LW-1:0]         ranked;
    logic [LW-1:0]         lvl;
    logic [DW-1:0]         elapsed;
    logic                  dropped;
    logic                  due;
    logic [CW-1:0]         lvl_c;
    logic [CW-1:0]         mel_c;
    logic                  evict;
    logic [WI-1:0]         tgt_idx;
    logic [DW:0]           target;
    logic [DW:0]           shortfall;
    logic [DW-1:0]         min_target;
    logic                  mode_cont;

    // bounds of the current level, widened by the debounce margin
    always_comb begin
        lo_idx   = WI'(i_cur_level - LW'(1));
        up_idx   = (i_cur_level < TOP_LEVEL) ? i_cur_level[WI-1:0] : '0;
        w_lo     = i_wm[lo_idx];
        lower    = (i_cur_level == '0) ? '0 :
                   (w_lo > i_cfg.debounce_pages) ? (w_lo - i_cfg.debounce_pages) : '0;
        upper    = {1'b0, i_wm[up_idx]} + {1'b0, i_cfg.debounce_pages};
        in_range = (i_free_cnt >= lower) &&
                   ((i_cur_level == TOP_LEVEL) || ({1'b0, i_free_cnt} <= upper));
    end

    // re-rank: count of leading watermarks exceeded
    always_comb begin
        for (int i = 0; i < NUM_WATERMARKS; i++) begin
            above[i] = i_free_cnt > i_wm[i];
        end
        ranked = TOP_LEVEL;
        for (int i = NUM_WATERMARKS - 1; i >= 0; i--) begin
            if (!above[i]) begin
                ranked = LW'(i);
            end
        end
    end

    // new level and signal decision
    always_comb begin
        mode_cont = i_cfg.mode_flags[mpl_pkg::MODE_CONTINUOUS];
        lvl = in_range ? i_cur_level : ranked;
        if (i_cfg.mode_flags[mpl_pkg::MODE_OOM_ON_FAIL] && i_alloc_failed) begin
            lvl = '0;
        end
        elapsed = i_now_ticks - i_last_time;
        dropped = lvl < i_sig_level;
        due     = dropped || (elapsed >= i_cfg.hysteresis_ticks);
        lvl_c   = CW'(lvl);
        mel_c   = CW'(i_cfg.max_evict_level);
        evict   = due && dropped && (lvl_c <= mel_c) && (lvl != '0);
    end

    // minimum free target for an eviction request
    always_comb begin
        tgt_idx = (32'(i_cfg.max_evict_level) >= 32'(NUM_WATERMARKS)) ?
                  WI'(NUM_WATERMARKS - 1) : WI'(i_cfg.max_evict_level);
        target    = {1'b0, i_wm[tgt_idx]} + {1'b0, i_cfg.debounce_pages};
        shortfall = target - {1'b0, i_free_cnt};
        min_target = '0;
        if (evict && i_cfg.mode_flags[mpl_pkg::MODE_EVICT_TARGET] &&
            ({1'b0, i_free_cnt} < target)) begin
            min_target = shortfall[DW:1];
        end
    end

    // next state
    always_comb begin
        o_cont_on = i_cont_on;
        if (due) begin
            if (evict) begin
                if (mode_cont) begin
                    o_cont_on = 1'b1;
                end
            end else if (mode_cont && (lvl_c > mel_c)) begin
                o_cont_on = 1'b0;
            end
        end
        o_level     = lvl;
        o_sig_level = due ? lvl : i_sig_level;
    end

    // result word
    always_comb begin
        o_result.level             = mpl_pkg::LEVEL_W'(lvl);
        o_result.signal_due        = due;
        o_result.cleared_level     = mpl_pkg::LEVEL_W'(i_sig_level);
        o_result.evict_request     = evict;
        o_result.min_free_target   = min_target;
        o_result.continuous_active = o_cont_on;
        o_result.oom_response      = due && (lvl == '0);
    end

endmodule
